>>> src/push_to_talk_button_classifier_assert.svh
// Assertion macros for the push-to-talk button classifier.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef PUSH_TO_TALK_BUTTON_CLASSIFIER_ASSERT_SVH
`define PUSH_TO_TALK_BUTTON_CLASSIFIER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequence must hold in the same cycle as the condition.
`define PTTBC_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: label");

// The consequence must hold in the cycle after the condition.
`define PTTBC_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define PTTBC_ASSERT_SAME(label, clk, rst, cond, cons)
`define PTTBC_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

>>> src/pttbc_pkg.sv
package pttbc_pkg;

   // Width of the internal press counter; it must lie between 16 and 32.
   localparam int DURATION_WIDTH = 24;

   localparam int THRESHOLD_WIDTH = 16;
   localparam int WINDOW_WIDTH    = 16;
   localparam int SESSION_WIDTH   = 32;
   localparam int OUT_DUR_WIDTH   = 24;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HOLD_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DOUBLE_WINDOW  = 2'd1;

   localparam logic [THRESHOLD_WIDTH-1:0] HOLD_THRESHOLD_RESET = 16'd300;
   localparam logic [WINDOW_WIDTH-1:0]    DOUBLE_WINDOW_RESET  = 16'd400;
   localparam logic [SESSION_WIDTH-1:0]   SESSION_RESET        = 32'd1;

   localparam logic [DURATION_WIDTH-1:0] DUR_MAX     = '1;
   localparam logic [OUT_DUR_WIDTH-1:0]  OUT_DUR_MAX = '1;
   localparam logic [WINDOW_WIDTH-1:0]   WIN_MAX     = '1;

   typedef enum logic [1:0] {
      EVENT_START  = 2'd0,
      EVENT_STOP   = 2'd1,
      EVENT_DOUBLE = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [THRESHOLD_WIDTH-1:0] hold_threshold_ms;
      logic [WINDOW_WIDTH-1:0]    double_window_ms;
   } cfg_type;

   typedef struct packed {
      logic                       valid;
      event_kind_type             event_kind;
      logic [SESSION_WIDTH-1:0]   session_number;
      logic [OUT_DUR_WIDTH-1:0]   press_duration_ms;
   } result_type;

   // Clamps an internal press length to the width of the result field.
   function automatic logic [OUT_DUR_WIDTH-1:0] clamp_duration(
      input logic [DURATION_WIDTH-1:0] dur
   );
      logic [31:0] wide;
      wide = 32'(dur);
      if (wide > 32'(OUT_DUR_MAX)) begin
         return OUT_DUR_MAX;
      end
      return wide[OUT_DUR_WIDTH-1:0];
   endfunction

endpackage

>>> src/pttbc_if.sv
// Request channel: one sampled button level per transfer.
interface pttbc_req_if import pttbc_pkg::*; ();
   logic valid;
   logic ready;
   logic pressed;

   modport source (output valid, output pressed, input ready);
   modport sink   (input valid, input pressed, output ready);
endinterface

// Response channel: one classified event per transfer.
interface pttbc_rsp_if import pttbc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               event_kind;
   logic [SESSION_WIDTH-1:0] session_number;
   logic [OUT_DUR_WIDTH-1:0] press_duration_ms;

   modport source (output valid, output event_kind, output session_number,
                   output press_duration_ms, input ready);
   modport sink   (input valid, input event_kind, input session_number,
                   input press_duration_ms, output ready);
endinterface

>>> src/pttbc_cfg.sv
// Configuration registers; writes to unknown indexes are dropped.
module pttbc_cfg import pttbc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_HOLD_THRESHOLD: cfg_in.hold_threshold_ms = csr_write_data;
            REG_DOUBLE_WINDOW:  cfg_in.double_window_ms  = csr_write_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_threshold_ms <= HOLD_THRESHOLD_RESET;
         cfg_ff.double_window_ms  <= DOUBLE_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/pttbc_core.sv
// Classifier state and the per-tick update. The state advances only when
// the top level moves an item out of its input register.
module pttbc_core import pttbc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       pressed,
   input  cfg_type    cfg,
   output result_type result
);

   logic                      last_level_ff, last_level_in;
   logic                      recording_ff, recording_in;
   logic [DURATION_WIDTH-1:0] press_ticks_ff, press_ticks_in;
   logic                      click_armed_ff, click_armed_in;
   logic [WINDOW_WIDTH-1:0]   since_release_ff, since_release_in;
   logic [SESSION_WIDTH-1:0]  session_ff, session_in;
   logic [DURATION_WIDTH-1:0] stop_duration;

   always_comb begin
      last_level_in    = pressed;
      recording_in     = recording_ff;
      press_ticks_in   = press_ticks_ff;
      click_armed_in   = click_armed_ff;
      since_release_in = since_release_ff;
      session_in       = session_ff;

      result                   = '0;
      result.session_number    = session_ff;
      result.event_kind        = EVENT_START;

      stop_duration = (press_ticks_ff < DUR_MAX) ? press_ticks_ff + 1'b1 : DUR_MAX;

      // The double-click window keeps counting while armed, even over a press.
      if (click_armed_ff && since_release_ff < WIN_MAX) begin
         since_release_in = since_release_ff + 1'b1;
      end

      if (pressed) begin
         if (!last_level_ff) begin
            press_ticks_in = '0;
         end else if (press_ticks_ff < DUR_MAX) begin
            press_ticks_in = press_ticks_ff + 1'b1;
         end
         if (!recording_ff &&
             press_ticks_in >= DURATION_WIDTH'(cfg.hold_threshold_ms)) begin
            recording_in      = 1'b1;
            result.valid      = 1'b1;
            result.event_kind = EVENT_START;
         end
      end else if (last_level_ff) begin
         if (recording_ff) begin
            result.valid             = 1'b1;
            result.event_kind        = EVENT_STOP;
            result.press_duration_ms = clamp_duration(stop_duration);
            session_in               = session_ff + 1'b1;
            recording_in             = 1'b0;
         end else if (click_armed_ff && since_release_in < cfg.double_window_ms) begin
            result.valid      = 1'b1;
            result.event_kind = EVENT_DOUBLE;
            click_armed_in    = 1'b0;
            since_release_in  = '0;
         end else begin
            click_armed_in   = 1'b1;
            since_release_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff    <= 1'b0;
         recording_ff     <= 1'b0;
         press_ticks_ff   <= '0;
         click_armed_ff   <= 1'b0;
         since_release_ff <= '0;
         session_ff       <= SESSION_RESET;
      end else if (advance) begin
         last_level_ff    <= last_level_in;
         recording_ff     <= recording_in;
         press_ticks_ff   <= press_ticks_in;
         click_armed_ff   <= click_armed_in;
         since_release_ff <= since_release_in;
         session_ff       <= session_in;
      end
   end

endmodule

>>> src/push_to_talk_button_classifier.sv
// Push-to-talk button classifier. Send one transfer per millisecond tick on
// the request channel carrying the sampled button level. A press held for
// more than hold_threshold_ms ticks (register 0) produces a recording start
// with the current session number; releasing it produces a recording stop
// with the press length in ticks, after which the session number advances.
// A short release that follows the previous short release within
// double_window_ms ticks (register 1) produces a double click. Ticks that
// cause no event produce no response transfer. The block takes one request
// per clock cycle unless the response channel stalls; an event passes from
// the input register through the state update into the result register
// before it reaches the response channel. Write the registers only while
// no request is in flight. There is no debouncing: feed it a clean level.
`include "push_to_talk_button_classifier_assert.svh"

module push_to_talk_button_classifier import pttbc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   pttbc_req_if.sink                  req_bus,
   pttbc_rsp_if.source                rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type    cfg;
   result_type result;

   // Input register: holds one accepted tick until the state can take it.
   logic in_valid_ff, in_valid_in;
   logic in_pressed_ff;

   // Result register: holds one event until the response transfer.
   logic                     rsp_valid_ff, rsp_valid_in;
   event_kind_type           rsp_kind_ff;
   logic [SESSION_WIDTH-1:0] rsp_session_ff;
   logic [OUT_DUR_WIDTH-1:0] rsp_duration_ff;

   logic advance;
   logic load_result;
   logic req_take;

   pttbc_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pttbc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pressed (in_pressed_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // A tick leaves the input register whenever the result register is free
   // or is being emptied in this cycle; while a result waits unaccepted, the
   // held tick stays put and the request side stalls.
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign load_result = advance && result.valid;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pressed_ff <= req_bus.pressed;
      end
      if (load_result) begin
         rsp_kind_ff     <= result.event_kind;
         rsp_session_ff  <= result.session_number;
         rsp_duration_ff <= result.press_duration_ms;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.event_kind        = rsp_kind_ff;
   assign rsp_bus.session_number    = rsp_session_ff;
   assign rsp_bus.press_duration_ms = rsp_duration_ff;

   // A stop always reports at least one tick of press length.
   `PTTBC_ASSERT_SAME(a_stop_has_duration, clock, reset,
      rsp_valid_ff && rsp_kind_ff == EVENT_STOP, rsp_duration_ff != '0)

   // Starts and double clicks carry no duration.
   `PTTBC_ASSERT_SAME(a_other_zero_duration, clock, reset,
      rsp_valid_ff && rsp_kind_ff != EVENT_STOP, rsp_duration_ff == '0)

   // A waiting result is never overwritten by a new event.
   `PTTBC_ASSERT_SAME(a_no_overwrite, clock, reset,
      rsp_valid_ff && !rsp_bus.ready, !load_result)

   // An accepted tick is held in the input register in the following cycle.
   `PTTBC_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_take, in_valid_ff)

endmodule
